// ===== rtl/oversampled_fan_decimator_top_macros.svh =====
// Assertion macros shared by the fan decimator RTL.
`ifndef OVERSAMPLED_FAN_DECIMATOR_TOP_MACROS_SVH
`define OVERSAMPLED_FAN_DECIMATOR_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define OFD_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define OFD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ofd_pkg.sv =====
`timescale 1ns / 1ps
// Types, constants and layout functions of the fan decimator.
package ofd_pkg;

   localparam int unsigned HEADER_WORDS = 2;
   localparam int unsigned DWELL_COUNT  = 7;

   localparam int unsigned WORD_W      = 16;
   localparam int unsigned POS_W       = 13;
   localparam int unsigned IDX_W       = 11;
   localparam int unsigned ACC_W       = 21;
   localparam int unsigned QUOT_W      = 8;
   localparam int unsigned FACTOR_W    = 5;
   localparam int unsigned OSI_W       = 2;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 2;

   localparam int unsigned QUEUE_DEPTH = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_OVERSAMPLE_INDEX    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAMERA_DWELL_AT_END = 2'd1;

   localparam logic [2:0] GROUP_DWELL  = 3'd5;
   localparam logic [2:0] CAMERA_DWELL = 3'd6;

   localparam logic [IDX_W-1:0] GROUP_LOGICAL_START  = 11'd857;
   localparam logic [IDX_W-1:0] CAMERA_LOGICAL_START = 11'd1028;
   localparam logic [IDX_W-1:0] LAST_GROUP_INDEX     = 11'd1027;
   localparam logic [IDX_W-1:0] LAST_CAMERA_INDEX    = 11'd1283;

   localparam logic [WORD_W-1:0] SAT_VALUE = 16'hFFFF;

   // off / 29 for off < 4959: (off * 4520) >> 17
   localparam logic [POS_W-1:0] OFF_RECIP_29    = 13'd4520;
   localparam int unsigned      OFF_RECIP_SHIFT = 17;
   // (4 * acc) / 29 for 4 * acc < 9.5M: (acc * 9256396) >> 26
   localparam logic [23:0]      ACC_RECIP_29    = 24'd9256396;
   localparam int unsigned      ACC_RECIP_SHIFT = 26;

   // physical slot -> logical dwell; row 0 camera in the middle, row 1 at the end
   localparam logic [2:0] DWELL_ORDER [2][DWELL_COUNT] = '{
      '{3'd0, 3'd1, 3'd2, 3'd6, 3'd3, 3'd4, 3'd5},
      '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6}
   };

   typedef enum logic [1:0] {
      KIND_HEADER,
      KIND_PLAIN,
      KIND_CAMERA,
      KIND_GROUP
   } ofd_kind_type;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      ofd_kind_type      kind;
      logic [POS_W-1:0]  offset;
      logic [IDX_W-1:0]  index;
      logic [OSI_W-1:0]  osi;
      logic              fan_end;
   } ofd_desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } ofd_queue_status_type;

   function automatic logic [POS_W-1:0] fan_length(input logic [OSI_W-1:0] osi);
      logic [POS_W-1:0] len;
      case (osi)
         2'd0:    len = 13'd1284;
         2'd1:    len = 13'd1797;
         2'd2:    len = 13'd3849;
         2'd3:    len = 13'd6072;
         default: len = 13'd1284;
      endcase
      return len;
   endfunction

   function automatic logic [FACTOR_W-1:0] group_factor(input logic [OSI_W-1:0] osi);
      logic [FACTOR_W-1:0] f;
      case (osi)
         2'd0:    f = 5'd1;
         2'd1:    f = 5'd4;
         2'd2:    f = 5'd16;
         2'd3:    f = 5'd29;
         default: f = 5'd1;
      endcase
      return f;
   endfunction

   function automatic logic [POS_W-1:0] dwell_length(input logic [2:0] d,
                                                     input logic [OSI_W-1:0] osi);
      logic [POS_W-1:0] len;
      len = 13'd171;
      if (d == CAMERA_DWELL) begin
         len = 13'd256;
      end else if (d == GROUP_DWELL) begin
         case (osi)
            2'd0:    len = 13'd171;
            2'd1:    len = 13'd684;
            2'd2:    len = 13'd2736;
            2'd3:    len = 13'd4959;
            default: len = 13'd171;
         endcase
      end
      return len;
   endfunction

   // offset of a physical slot from the end of the header
   function automatic logic [POS_W-1:0] dwell_start(input logic [OSI_W-1:0] osi,
                                                    input logic cam_end,
                                                    input logic [2:0] slot);
      logic [POS_W-1:0] sum;
      int               j;
      sum = '0;
      for (j = 0; j < DWELL_COUNT; j++) begin
         if (3'(j) < slot) begin
            sum = sum + dwell_length(DWELL_ORDER[cam_end][j], osi);
         end
      end
      return sum;
   endfunction

   // logical start of short dwells 0..4
   function automatic logic [IDX_W-1:0] plain_base(input logic [2:0] d);
      logic [IDX_W-1:0] base;
      case (d)
         3'd0:    base = 11'd2;
         3'd1:    base = 11'd173;
         3'd2:    base = 11'd344;
         3'd3:    base = 11'd515;
         3'd4:    base = 11'd686;
         default: base = 11'd0;
      endcase
      return base;
   endfunction

endpackage

// ===== rtl/oversampled_fan_decimator_top.sv =====
`timescale 1ns / 1ps
// Top level of the oversampled fan decimator.
//
// Usage:
//   req_* carries one raw 16-bit detector word per transfer (valid/stall).
//   rsp_* carries zero or one result per word: the value, its index in the
//   1284-entry logical fan and a fan_end flag on the fan's last raw word.
//   Header and short dwell words each give a result; dwell 5 gives one
//   result per completed group of 1, 4, 16 or 29 words.
//   csr_* writes oversample_index (index 0) and camera_dwell_at_end
//   (index 1); write only while no word is in flight.
// Timing:
//   After its word's transfer, a result passes through the descriptor queue,
//   then the group-quotient stage, the accumulate stage and the result
//   register. One word per cycle is sustained while the result is not stalled.
//   The front end keeps taking words while the result is stalled, until the
//   QueueDepth-entry queue fills; req_stall then rises.
// Reset:
//   Synchronous, active high. Clears both CSRs, the fan position, the
//   queue, the pipeline and the group sum; the next word is header word 0.
`include "oversampled_fan_decimator_top_macros.svh"

module oversampled_fan_decimator_top #(
   parameter int unsigned QueueDepth = ofd_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ofd_pkg::WORD_W-1:0]      req_raw_word,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ofd_pkg::WORD_W-1:0]      rsp_value,
   output logic [ofd_pkg::IDX_W-1:0]       rsp_logical_index,
   output logic                            rsp_fan_end,
   input  logic                            csr_write_enable,
   input  logic [ofd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ofd_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   ofd_pkg::ofd_queue_status_type q_status;
   ofd_pkg::ofd_desc_type         q_push_desc;
   ofd_pkg::ofd_desc_type         q_pop_desc;
   logic                          q_push;
   logic                          q_pop;

   // front end: classify each word against the current fan layout
   ofd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_raw_word     (req_raw_word),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .queue_status     (q_status),
      .push             (q_push),
      .push_desc        (q_push_desc)
   );

   // decouples input transfers from output stalls
   ofd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_desc),
      .pop       (q_pop),
      .pop_data  (q_pop_desc),
      .status    (q_status)
   );

   // back end: arithmetic and result register
   ofd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .queue_status      (q_status),
      .pop_desc          (q_pop_desc),
      .pop               (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_value         (rsp_value),
      .rsp_logical_index (rsp_logical_index),
      .rsp_fan_end       (rsp_fan_end)
   );

   // fan end always lands on the last camera sample or the last group
   `OFD_ASSERT_IMPLY(a_fan_end_index, rsp_valid && rsp_fan_end,
      rsp_logical_index == ofd_pkg::LAST_CAMERA_INDEX ||
      rsp_logical_index == ofd_pkg::LAST_GROUP_INDEX,
      "fan end on an unexpected logical index")

   `OFD_ASSERT_IMPLY(a_index_range, rsp_valid,
      rsp_logical_index <= ofd_pkg::LAST_CAMERA_INDEX,
      "logical index beyond the fan")

   // a word written into the queue is still there or being read next cycle
   `OFD_ASSERT_NEXT(a_queue_holds, q_push, !q_status.empty,
      "queue empty right after a write")

endmodule

// ===== rtl/ofd_front.sv =====
`timescale 1ns / 1ps
// Front end: CSRs, fan position tracking and word classification.
module ofd_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [ofd_pkg::WORD_W-1:0]             req_raw_word,
   input  logic                                   csr_write_enable,
   input  logic [ofd_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [ofd_pkg::CSR_DATA_W-1:0]         csr_write_data,
   input  ofd_pkg::ofd_queue_status_type          queue_status,
   output logic                                   push,
   output ofd_pkg::ofd_desc_type                  push_desc
);

   logic [ofd_pkg::OSI_W-1:0] osi_ff, osi_in;
   logic                      cam_end_ff, cam_end_in;
   logic [ofd_pkg::POS_W-1:0] word_pos_ff, word_pos_in;

   logic [ofd_pkg::POS_W-1:0] fan_len;
   logic [ofd_pkg::POS_W-1:0] pos;
   logic                      last_word;
   logic [ofd_pkg::POS_W-1:0] offset;
   logic [ofd_pkg::POS_W-1:0] starts [ofd_pkg::DWELL_COUNT];
   logic [2:0]                slot;
   logic [2:0]                dwell;
   logic [ofd_pkg::POS_W-1:0] dwell_off;

   assign req_stall = queue_status.full;
   assign push      = req_valid && !queue_status.full;

   always_comb begin
      osi_in     = osi_ff;
      cam_end_in = cam_end_ff;
      if (csr_write_enable) begin
         case (csr_index)
            ofd_pkg::CSR_OVERSAMPLE_INDEX:    osi_in     = csr_write_data[1:0];
            ofd_pkg::CSR_CAMERA_DWELL_AT_END: cam_end_in = csr_write_data[0];
            default: ;
         endcase
      end
   end

   // layout always follows the current CSRs; a stale position restarts the fan
   always_comb begin
      fan_len   = ofd_pkg::fan_length(osi_ff);
      pos       = (word_pos_ff >= fan_len) ? '0 : word_pos_ff;
      last_word = (pos == fan_len - 13'd1);
      offset    = pos - 13'(ofd_pkg::HEADER_WORDS);

      for (int k = 0; k < ofd_pkg::DWELL_COUNT; k++) begin
         starts[k] = ofd_pkg::dwell_start(osi_ff, cam_end_ff, 3'(k));
      end

      slot = '0;
      for (int k = 1; k < ofd_pkg::DWELL_COUNT; k++) begin
         if (offset >= starts[k]) begin
            slot = 3'(k);
         end
      end
      dwell     = ofd_pkg::DWELL_ORDER[cam_end_ff][slot];
      dwell_off = offset - starts[slot];

      word_pos_in = word_pos_ff;
      if (push) begin
         word_pos_in = last_word ? '0 : pos + 13'd1;
      end
   end

   always_comb begin
      push_desc.word    = req_raw_word;
      push_desc.offset  = dwell_off;
      push_desc.osi     = osi_ff;
      push_desc.fan_end = last_word;
      if (pos < 13'(ofd_pkg::HEADER_WORDS)) begin
         push_desc.kind  = ofd_pkg::KIND_HEADER;
         push_desc.index = pos[ofd_pkg::IDX_W-1:0];
      end else if (dwell == ofd_pkg::GROUP_DWELL) begin
         push_desc.kind  = ofd_pkg::KIND_GROUP;
         push_desc.index = ofd_pkg::GROUP_LOGICAL_START;
      end else if (dwell == ofd_pkg::CAMERA_DWELL) begin
         push_desc.kind  = ofd_pkg::KIND_CAMERA;
         push_desc.index = ofd_pkg::CAMERA_LOGICAL_START + dwell_off[ofd_pkg::IDX_W-1:0];
      end else begin
         push_desc.kind  = ofd_pkg::KIND_PLAIN;
         push_desc.index = ofd_pkg::plain_base(dwell) + dwell_off[ofd_pkg::IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         osi_ff      <= '0;
         cam_end_ff  <= 1'b0;
         word_pos_ff <= '0;
      end else begin
         osi_ff      <= osi_in;
         cam_end_ff  <= cam_end_in;
         word_pos_ff <= word_pos_in;
      end
   end

endmodule

// ===== rtl/ofd_queue.sv =====
`timescale 1ns / 1ps
// Small descriptor FIFO between the front end and the back end.
module ofd_queue #(
   parameter int unsigned Depth = ofd_pkg::QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  ofd_pkg::ofd_desc_type         push_data,
   input  logic                          pop,
   output ofd_pkg::ofd_desc_type         pop_data,
   output ofd_pkg::ofd_queue_status_type status
);

   localparam int unsigned PTR_W = $clog2(Depth);
   localparam int unsigned CNT_W = $clog2(Depth + 1);

   ofd_pkg::ofd_desc_type mem_ff [Depth];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;

   assign pop_data     = mem_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(Depth));
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/ofd_back.sv =====
`timescale 1ns / 1ps
// Back end: scaling, group accumulation, division and the result register.
module ofd_back (
   input  logic                            clock,
   input  logic                            reset,
   input  ofd_pkg::ofd_queue_status_type   queue_status,
   input  ofd_pkg::ofd_desc_type           pop_desc,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ofd_pkg::WORD_W-1:0]      rsp_value,
   output logic [ofd_pkg::IDX_W-1:0]       rsp_logical_index,
   output logic                            rsp_fan_end
);

   logic advance;

   // stage 1: quotient of the group offset, scaled sample
   logic                       s1_valid_ff, s1_valid_in;
   ofd_pkg::ofd_kind_type      s1_kind_ff;
   logic [ofd_pkg::WORD_W-1:0] s1_word_ff;
   logic [ofd_pkg::WORD_W-1:0] s1_val_ff, s1_val_in;
   logic [ofd_pkg::IDX_W-1:0]  s1_idx_ff;
   logic [ofd_pkg::POS_W-1:0]  s1_off_ff;
   logic [ofd_pkg::QUOT_W-1:0] s1_quot_ff, s1_quot_in;
   logic [ofd_pkg::OSI_W-1:0]  s1_osi_ff;
   logic                       s1_end_ff;
   logic [25:0]                off_prod;

   // stage 2: group sum and camera repeat
   logic                         s2_valid_ff, s2_valid_in;
   logic                         s2_group_ff;
   logic [ofd_pkg::ACC_W-1:0]    s2_acc_ff;
   logic [ofd_pkg::OSI_W-1:0]    s2_osi_ff;
   logic [ofd_pkg::WORD_W-1:0]   s2_val_ff, s2_val_in;
   logic [ofd_pkg::IDX_W-1:0]    s2_idx_ff, s2_idx_in;
   logic                         s2_end_ff;
   logic [ofd_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic [ofd_pkg::WORD_W-1:0]   prev_cam_ff, prev_cam_in;
   logic [ofd_pkg::FACTOR_W-1:0] factor;
   logic [ofd_pkg::POS_W-1:0]    group_rem;
   logic                         group_last;
   logic [ofd_pkg::ACC_W-1:0]    acc_sum;

   // result register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [ofd_pkg::WORD_W-1:0] rsp_value_ff, rsp_value_in;
   logic [ofd_pkg::IDX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic                       rsp_end_ff, rsp_end_in;
   logic [44:0]                acc_prod;
   logic [22:0]                group_quo;

   // the whole pipe moves unless a held result is stalled
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop     = advance && !queue_status.empty;

   always_comb begin
      off_prod = 26'(pop_desc.offset) * 26'(ofd_pkg::OFF_RECIP_29);
      case (pop_desc.osi)
         2'd0:    s1_quot_in = pop_desc.offset[ofd_pkg::QUOT_W-1:0];
         2'd1:    s1_quot_in = ofd_pkg::QUOT_W'(pop_desc.offset >> 2);
         2'd2:    s1_quot_in = ofd_pkg::QUOT_W'(pop_desc.offset >> 4);
         2'd3:    s1_quot_in = ofd_pkg::QUOT_W'(off_prod >> ofd_pkg::OFF_RECIP_SHIFT);
         default: s1_quot_in = pop_desc.offset[ofd_pkg::QUOT_W-1:0];
      endcase
      if (pop_desc.kind == ofd_pkg::KIND_HEADER) begin
         s1_val_in = pop_desc.word;
      end else if (pop_desc.word[15:14] != 2'b00) begin
         s1_val_in = ofd_pkg::SAT_VALUE;
      end else begin
         s1_val_in = {pop_desc.word[13:0], 2'b00};
      end
      s1_valid_in = advance ? pop : s1_valid_ff;
   end

   always_comb begin
      factor     = ofd_pkg::group_factor(s1_osi_ff);
      group_rem  = s1_off_ff - 13'(s1_quot_ff) * 13'(factor);
      group_last = (group_rem == 13'(factor) - 13'd1);
      acc_sum    = ((group_rem == '0) ? '0 : acc_ff) + ofd_pkg::ACC_W'(s1_word_ff);

      acc_in      = acc_ff;
      prev_cam_in = prev_cam_ff;
      s2_val_in   = s1_val_ff;
      s2_idx_in   = s1_idx_ff;
      s2_valid_in = s2_valid_ff;

      case (s1_kind_ff)
         ofd_pkg::KIND_GROUP: begin
            s2_idx_in = ofd_pkg::GROUP_LOGICAL_START + ofd_pkg::IDX_W'(s1_quot_ff);
         end
         ofd_pkg::KIND_CAMERA: begin
            if (s1_off_ff == 13'd127 || s1_off_ff == 13'd255) begin
               s2_val_in = prev_cam_ff;
            end
         end
         default: ;
      endcase

      if (advance) begin
         s2_valid_in = s1_valid_ff &&
                       (s1_kind_ff != ofd_pkg::KIND_GROUP || group_last);
         if (s1_valid_ff && s1_kind_ff == ofd_pkg::KIND_GROUP) begin
            acc_in = group_last ? '0 : acc_sum;
         end
         if (s1_valid_ff && s1_kind_ff == ofd_pkg::KIND_CAMERA) begin
            prev_cam_in = s2_val_in;
         end
      end
   end

   always_comb begin
      acc_prod = 45'(s2_acc_ff) * 45'(ofd_pkg::ACC_RECIP_29);
      case (s2_osi_ff)
         2'd0:    group_quo = {s2_acc_ff, 2'b00};
         2'd1:    group_quo = 23'(s2_acc_ff);
         2'd2:    group_quo = 23'(s2_acc_ff >> 2);
         2'd3:    group_quo = 23'(acc_prod >> ofd_pkg::ACC_RECIP_SHIFT);
         default: group_quo = 23'(s2_acc_ff);
      endcase

      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_end_in   = rsp_end_ff;
      if (advance) begin
         rsp_valid_in = s2_valid_ff;
         rsp_idx_in   = s2_idx_ff;
         rsp_end_in   = s2_end_ff;
         if (!s2_group_ff) begin
            rsp_value_in = s2_val_ff;
         end else if (group_quo > 23'(ofd_pkg::SAT_VALUE)) begin
            rsp_value_in = ofd_pkg::SAT_VALUE;
         end else begin
            rsp_value_in = group_quo[ofd_pkg::WORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_kind_ff  <= pop_desc.kind;
         s1_word_ff  <= pop_desc.word;
         s1_val_ff   <= s1_val_in;
         s1_idx_ff   <= pop_desc.index;
         s1_off_ff   <= pop_desc.offset;
         s1_quot_ff  <= s1_quot_in;
         s1_osi_ff   <= pop_desc.osi;
         s1_end_ff   <= pop_desc.fan_end;
         s2_group_ff <= (s1_kind_ff == ofd_pkg::KIND_GROUP);
         s2_acc_ff   <= acc_sum;
         s2_osi_ff   <= s1_osi_ff;
         s2_val_ff   <= s2_val_in;
         s2_idx_ff   <= s2_idx_in;
         s2_end_ff   <= s1_end_ff;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_end_ff   <= rsp_end_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
         prev_cam_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         acc_ff       <= acc_in;
         prev_cam_ff  <= prev_cam_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_value         = rsp_value_ff;
   assign rsp_logical_index = rsp_idx_ff;
   assign rsp_fan_end       = rsp_end_ff;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the oversampled fan decimator top level.
module tb_top;

   // Fan layout as seen by the scoreboard
   localparam int unsigned SHORT_LEN     = 171;
   localparam int unsigned CAMERA_LEN    = 256;
   // header + five short dwells + camera dwell; dwell 5 adds 171 * factor
   localparam int unsigned FIXED_FAN_LEN = 1113;
   // camera samples that repeat their predecessor
   localparam int unsigned CAMERA_REPEAT_MID  = 127;
   localparam int unsigned CAMERA_REPEAT_LAST = 255;

   localparam int unsigned GROUP_FACTORS [4] = '{1, 4, 16, 29};
   // physical slot -> logical dwell, row selected by camera_dwell_at_end
   localparam logic [2:0] SLOT_DWELL [2][ofd_pkg::DWELL_COUNT] = '{
      '{3'd0, 3'd1, 3'd2, 3'd6, 3'd3, 3'd4, 3'd5},
      '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6}
   };

   // Result pipeline plus the 4-entry descriptor queue
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned LONG_HOLD     = 40;
   localparam int unsigned CYCLE_LIMIT   = 200000;

   // Header extremes first, then the x4 saturation boundary and bit patterns
   localparam int unsigned DIRECTED_COUNT = 16;
   localparam logic [ofd_pkg::WORD_W-1:0] DIRECTED_WORDS [DIRECTED_COUNT] = '{
      16'hFFFF, 16'h0000, 16'h3FFF, 16'h4000, 16'hFFFF, 16'h0000, 16'h0001, 16'h8000,
      16'h7FFF, 16'hAAAA, 16'h5555, 16'h3FFE, 16'h4001, 16'hC000, 16'h0FFF, 16'hF000
   };

   typedef struct packed {
      logic [ofd_pkg::WORD_W-1:0] value;
      logic [ofd_pkg::IDX_W-1:0]  index;
      logic                       fan_end;
   } fan_result_type;

   typedef enum logic [1:0] {
      STYLE_FULL,
      STYLE_LOW,
      STYLE_EDGE,
      STYLE_EXTREME
   } word_style_type;

   // DUT ports; every input starts at a known value
   logic                            clock            = 1'b0;
   logic                            reset            = 1'b1;
   logic                            req_valid        = 1'b0;
   logic [ofd_pkg::WORD_W-1:0]      req_raw_word     = '0;
   logic                            rsp_stall        = 1'b0;
   logic                            csr_write_enable = 1'b0;
   logic [ofd_pkg::CSR_INDEX_W-1:0] csr_index        = ofd_pkg::CSR_OVERSAMPLE_INDEX;
   logic [ofd_pkg::CSR_DATA_W-1:0]  csr_write_data   = '0;
   logic                            req_stall;
   logic                            rsp_valid;
   logic [ofd_pkg::WORD_W-1:0]      rsp_value;
   logic [ofd_pkg::IDX_W-1:0]       rsp_logical_index;
   logic                            rsp_fan_end;

   // Scoreboard copy of the block state and configuration
   logic [ofd_pkg::POS_W-1:0]  fan_pos     = '0;
   logic [ofd_pkg::ACC_W-1:0]  group_sum   = '0;
   logic [ofd_pkg::WORD_W-1:0] camera_prev = '0;
   logic [ofd_pkg::OSI_W-1:0]  osi_setting = '0;
   logic                       cam_at_end  = 1'b0;

   logic [ofd_pkg::WORD_W-1:0] raw_words_pending [$];
   fan_result_type             results_due [$];

   int unsigned    words_taken        = 0;
   int unsigned    results_checked    = 0;
   int unsigned    mismatches         = 0;
   int unsigned    cycles             = 0;
   int unsigned    sender_idle_pct    = 22;
   int unsigned    receiver_stall_pct = 63;
   int unsigned    hold_requests      = 0;
   int unsigned    holds_served       = 0;
   int unsigned    hold_left          = 0;
   bit             req_taken          = 1'b0;
   word_style_type word_style         = STYLE_FULL;

   oversampled_fan_decimator_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_raw_word      (req_raw_word),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_value         (rsp_value),
      .rsp_logical_index (rsp_logical_index),
      .rsp_fan_end       (rsp_fan_end),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #5 clock = ~clock;

   function automatic logic [ofd_pkg::WORD_W-1:0] saturate16(input longint unsigned v);
      return (v > 64'd65535) ? ofd_pkg::SAT_VALUE : ofd_pkg::WORD_W'(v);
   endfunction

   // Works out the result (if any) of one raw word and queues it.
   task automatic predict_word(input logic [ofd_pkg::WORD_W-1:0] w);
      int unsigned    f;
      int unsigned    len;
      int unsigned    pos;
      int unsigned    off;
      int unsigned    seg;
      int unsigned    rem;
      int             k;
      logic [2:0]     d;
      bit             found;
      fan_result_type r;
      f   = GROUP_FACTORS[osi_setting];
      len = FIXED_FAN_LEN + SHORT_LEN * f;
      pos = fan_pos;
      // a shorter layout after a mid-fan change: this word opens a new fan
      if (pos >= len) begin
         pos = 0;
      end
      r.fan_end = (pos == len - 1);
      fan_pos   = r.fan_end ? '0 : ofd_pkg::POS_W'(pos + 1);
      if (pos < ofd_pkg::HEADER_WORDS) begin
         r.value = w;
         r.index = ofd_pkg::IDX_W'(pos);
         results_due.push_back(r);
      end else begin
         // walk the physical dwells to find the one holding this word
         off   = pos - ofd_pkg::HEADER_WORDS;
         d     = '0;
         found = 1'b0;
         for (k = 0; k < ofd_pkg::DWELL_COUNT; k++) begin
            if (!found) begin
               d   = SLOT_DWELL[cam_at_end][k];
               seg = (d == ofd_pkg::CAMERA_DWELL) ? CAMERA_LEN :
                     (d == ofd_pkg::GROUP_DWELL)  ? SHORT_LEN * f : SHORT_LEN;
               if (off < seg) begin
                  found = 1'b1;
               end else begin
                  off = off - seg;
               end
            end
         end
         if (d == ofd_pkg::GROUP_DWELL) begin
            // group position comes from the offset, so a partial sum survives a
            // factor change
            rem       = off % f;
            group_sum = ((rem == 0) ? ofd_pkg::ACC_W'(0) : group_sum) + ofd_pkg::ACC_W'(w);
            if (rem == f - 1) begin
               r.value = saturate16((longint'(group_sum) * 4) / f);
               r.index = ofd_pkg::GROUP_LOGICAL_START + ofd_pkg::IDX_W'(off / f);
               results_due.push_back(r);
               group_sum = '0;
            end
         end else if (d == ofd_pkg::CAMERA_DWELL) begin
            r.value = (off == CAMERA_REPEAT_MID || off == CAMERA_REPEAT_LAST) ?
                      camera_prev : saturate16(longint'(w) * 4);
            camera_prev = r.value;
            r.index     = ofd_pkg::CAMERA_LOGICAL_START + ofd_pkg::IDX_W'(off);
            results_due.push_back(r);
         end else begin
            r.value = saturate16(longint'(w) * 4);
            r.index = ofd_pkg::IDX_W'(ofd_pkg::HEADER_WORDS + d * SHORT_LEN + off);
            results_due.push_back(r);
         end
      end
   endtask

   function automatic void check_field(input string field, input int unsigned want,
                                       input int unsigned got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endfunction

   // Random content in runs of one style, so dwell-5 groups come out both
   // saturated and in range.
   function automatic logic [ofd_pkg::WORD_W-1:0] next_raw_word();
      logic [ofd_pkg::WORD_W-1:0] w;
      if ($urandom_range(0, 31) == 0) begin
         word_style = word_style_type'($urandom_range(0, 3));
      end
      case (word_style)
         STYLE_LOW: begin
            w = ofd_pkg::WORD_W'($urandom_range(0, 16'h3FFF));
         end
         STYLE_EDGE: begin
            w = ofd_pkg::WORD_W'($urandom_range(16'h3FF0, 16'h400F));
         end
         STYLE_EXTREME: begin
            w = ($urandom_range(0, 1) == 0) ? '0 : ofd_pkg::SAT_VALUE;
         end
         default: begin
            w = ofd_pkg::WORD_W'($urandom());
         end
      endcase
      return w;
   endfunction

   // Monitor: config shadow, result check and prediction, all on the rising edge
   always @(posedge clock) begin
      fan_result_type due;
      if (reset) begin
         req_taken   = 1'b0;
         fan_pos     = '0;
         group_sum   = '0;
         camera_prev = '0;
         osi_setting = '0;
         cam_at_end  = 1'b0;
      end else begin
         if (csr_write_enable) begin
            if (csr_index == ofd_pkg::CSR_OVERSAMPLE_INDEX) begin
               osi_setting = csr_write_data[ofd_pkg::OSI_W-1:0];
            end else if (csr_index == ofd_pkg::CSR_CAMERA_DWELL_AT_END) begin
               cam_at_end = csr_write_data[0];
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result, expected none, actual value %0d index %0d",
                        $time, rsp_value, rsp_logical_index);
            end else begin
               due = results_due.pop_front();
               check_field("value", due.value, rsp_value);
               check_field("logical_index", due.index, rsp_logical_index);
               check_field("fan_end", due.fan_end, rsp_fan_end);
               results_checked++;
            end
         end
         // driver reads this on the next falling edge
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            predict_word(req_raw_word);
            words_taken++;
         end
      end
   end

   // Driver: a payload holds until its transfer; gaps only between words
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (raw_words_pending.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            req_valid    <= 1'b1;
            req_raw_word <= raw_words_pending.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result back-pressure: random stalls, plus long holds on request so the
   // descriptor queue fills and req_stall rises
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else if (holds_served != hold_requests) begin
         rsp_stall <= 1'b1;
         holds_served = holds_served + 1;
         hold_left    = LONG_HOLD - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still expected",
                  cycles, results_due.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Block is idle once every word has gone in and every result has come out;
   // the settle covers dwell-5 words that produce nothing.
   task automatic wait_idle();
      do begin
         @(posedge clock);
      end while (raw_words_pending.size() != 0 || req_valid || results_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [ofd_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [ofd_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // One phase: drain, reprogram both registers, then queue the words.
   task automatic run_section(input logic [ofd_pkg::OSI_W-1:0] osi, input logic cam,
                              input int unsigned words, input int unsigned send_idle,
                              input int unsigned recv_stall, input bit with_directed);
      int unsigned i;
      wait_idle();
      sender_idle_pct    = send_idle;
      receiver_stall_pct = recv_stall;
      write_reg(ofd_pkg::CSR_OVERSAMPLE_INDEX, ofd_pkg::CSR_DATA_W'(osi));
      write_reg(ofd_pkg::CSR_CAMERA_DWELL_AT_END, ofd_pkg::CSR_DATA_W'(cam));
      @(posedge clock);
      if (with_directed) begin
         for (i = 0; i < DIRECTED_COUNT; i++) begin
            raw_words_pending.push_back(DIRECTED_WORDS[i]);
         end
      end
      repeat (words) raw_words_pending.push_back(next_raw_word());
   endtask

   // Fan position per phase: 0-800 camera in the middle, factor 1; 800-870
   // camera moved to the end, into dwell 5; 870-1183 dwell 5 under factors
   // 29, 4 and 16 with partial groups carried across; then factor 1 puts the
   // position in the camera dwell, which runs to the fan's last word, and the
   // next fan starts.
   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_section(2'd0, 1'b0, 784, 22, 63, 1'b1);
      wait (words_taken >= 400);
      hold_requests++;
      run_section(2'd0, 1'b1, 70, 63, 22, 1'b0);
      run_section(2'd3, 1'b1, 113, 63, 22, 1'b0);
      run_section(2'd1, 1'b1, 100, 63, 22, 1'b0);
      run_section(2'd2, 1'b1, 100, 63, 22, 1'b0);
      run_section(2'd0, 1'b1, 167, 0, 0, 1'b0);
      wait (words_taken >= 1300);
      hold_requests++;
      wait_idle();

      if (results_due.size() != 0) begin
         mismatches++;
         $display("%0t: %0d expected results never arrived", $time, results_due.size());
      end
      $display("Fan decimator: %0d words sent, %0d results checked, %0d mismatches",
               words_taken, results_checked, mismatches);
      $display("Covered camera dwell mid and end, group factors 1/4/16/29, mid-fan changes, fan end");
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
